// ===== rtl/fprp_pkg.sv =====
`default_nettype none

package fprp_pkg;

  localparam int unsigned LINE_CAP_DEF  = 511;
  localparam int unsigned REPLY_CAP_DEF = 1023;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_OPEN    = 8'h28;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 64;

  typedef struct packed {
    logic [15:0] pasv_port;
    logic [31:0] host_address;
    logic        pasv_ok;
    logic        hit_length_cap;
    logic [9:0]  reply_code;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c inside {[8'h30:8'h39]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fprp_in_reg.sv =====
`default_nettype none

module fprp_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_valid,
  output logic            s_ready,
  input  wire logic [7:0] s_data,
  input  wire logic       take,
  output logic            q_valid,
  output logic [7:0]      q_data
);

  // refill in the same cycle the held word is consumed
  assign s_ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_ready) begin
      q_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      q_data <= s_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fprp_parser.sv =====
`default_nettype none

module fprp_parser #(
  parameter int unsigned LINE_CAP  = fprp_pkg::LINE_CAP_DEF,
  parameter int unsigned REPLY_CAP = fprp_pkg::REPLY_CAP_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output logic            res_valid,
  output fprp_pkg::result_t res
);

  localparam int unsigned LLW = $clog2(LINE_CAP + 1);
  localparam int unsigned RLW = $clog2(REPLY_CAP + LINE_CAP + 1);

  localparam logic [2:0] PH_WAIT   = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_DONE   = 3'd3;
  localparam logic [2:0] PH_FAIL   = 3'd4;

  logic [LLW-1:0] line_length,  line_length_next;
  logic [RLW-1:0] reply_length, reply_length_next;
  logic [3:0]     line_head_ok, line_head_ok_next;
  logic [9:0]     code_accum,   code_accum_next;
  logic [1:0]     code_digits,  code_digits_next;
  logic [2:0]     pasv_phase,   pasv_phase_next;
  logic [2:0]     value_index,  value_index_next;
  logic [8:0]     value_accum,  value_accum_next;
  logic [31:0]    address_acc,  address_acc_next;
  logic [7:0]     port_high,    port_high_next;

  logic           digit;
  logic [3:0]     dval;
  logic [11:0]    value_mul;
  logic [LLW-1:0] line_inc;
  logic [RLW-1:0] reply_inc;
  logic           line_end;
  logic           done;
  logic           capped;
  logic           pasv_good;

  always_comb begin
    digit     = fprp_pkg::is_digit(rx_byte);
    dval      = rx_byte[3:0];
    value_mul = {3'b000, value_accum} * 12'd10 + {8'h00, dval};

    code_accum_next   = code_accum;
    code_digits_next  = code_digits;
    line_head_ok_next = line_head_ok;
    pasv_phase_next   = pasv_phase;
    value_index_next  = value_index;
    value_accum_next  = value_accum;
    address_acc_next  = address_acc;
    port_high_next    = port_high;

    // reply code from the leading digits of the reply
    if (code_digits != 2'd3 && reply_length == RLW'(code_digits) && digit) begin
      code_accum_next  = 10'(code_accum * 10'd10 + {6'b0, dval});
      code_digits_next = code_digits + 2'd1;
    end

    // final line head: three digits then a space
    if (line_length < LLW'(3)) begin
      if (digit && (line_length == '0 ||
                    line_head_ok[line_length[1:0] - 2'd1])) begin
        line_head_ok_next[line_length[1:0]] = 1'b1;
      end
    end else if (line_length == LLW'(3)) begin
      if (rx_byte == fprp_pkg::CHAR_SPACE && line_head_ok[2]) begin
        line_head_ok_next[3] = 1'b1;
      end
    end

    case (pasv_phase)
      PH_WAIT: begin
        if (rx_byte == fprp_pkg::CHAR_OPEN) begin
          pasv_phase_next  = PH_START;
          value_index_next = 3'd0;
          value_accum_next = 9'd0;
        end
      end
      PH_START: begin
        if (digit) begin
          value_accum_next = {5'b0, dval};
          pasv_phase_next  = PH_DIGITS;
        end else begin
          pasv_phase_next = PH_FAIL;
        end
      end
      PH_DIGITS: begin
        if (digit) begin
          if (value_mul > 12'd255) begin
            pasv_phase_next = PH_FAIL;
          end else begin
            value_accum_next = value_mul[8:0];
          end
        end else if (value_index >= 3'd5) begin
          pasv_phase_next = PH_DONE;
        end else if (rx_byte == fprp_pkg::CHAR_COMMA) begin
          if (value_index < 3'd4) begin
            address_acc_next = {address_acc[23:0], value_accum[7:0]};
          end else begin
            port_high_next = value_accum[7:0];
          end
          value_index_next = value_index + 3'd1;
          value_accum_next = 9'd0;
          pasv_phase_next  = PH_START;
        end else begin
          pasv_phase_next = PH_FAIL;
        end
      end
      default: begin
      end
    endcase

    line_inc  = line_length + LLW'(1);
    reply_inc = reply_length + RLW'(1);
    line_end  = (rx_byte == fprp_pkg::CHAR_NEWLINE) || (line_inc >= LLW'(LINE_CAP));

    done   = 1'b0;
    capped = 1'b0;
    if (line_end) begin
      if (line_head_ok_next[3]) begin
        done = 1'b1;
      end else if (reply_inc >= RLW'(REPLY_CAP)) begin
        done   = 1'b1;
        capped = 1'b1;
      end
    end

    // sixth value may be closed by the reply end itself
    pasv_good = (pasv_phase_next == PH_DONE) ||
                (pasv_phase_next == PH_DIGITS && value_index_next >= 3'd5);

    res_valid          = done;
    res.reply_code     = code_accum_next;
    res.hit_length_cap = capped;
    res.pasv_ok        = pasv_good;
    res.host_address   = pasv_good ? address_acc_next : 32'd0;
    res.pasv_port      = pasv_good ? {port_high_next, value_accum_next[7:0]} : 16'd0;

    line_length_next  = line_end ? '0 : line_inc;
    reply_length_next = reply_inc;
    if (line_end) begin
      line_head_ok_next = 4'd0;
    end

    // start a fresh reply
    if (done) begin
      reply_length_next = '0;
      code_accum_next   = 10'd0;
      code_digits_next  = 2'd0;
      pasv_phase_next   = PH_WAIT;
      value_index_next  = 3'd0;
      value_accum_next  = 9'd0;
      address_acc_next  = 32'd0;
      port_high_next    = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length  <= '0;
      reply_length <= '0;
      line_head_ok <= 4'd0;
      code_accum   <= 10'd0;
      code_digits  <= 2'd0;
      pasv_phase   <= PH_WAIT;
      value_index  <= 3'd0;
      value_accum  <= 9'd0;
      address_acc  <= 32'd0;
      port_high    <= 8'd0;
    end else if (step) begin
      line_length  <= line_length_next;
      reply_length <= reply_length_next;
      line_head_ok <= line_head_ok_next;
      code_accum   <= code_accum_next;
      code_digits  <= code_digits_next;
      pasv_phase   <= pasv_phase_next;
      value_index  <= value_index_next;
      value_accum  <= value_accum_next;
      address_acc  <= address_acc_next;
      port_high    <= port_high_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ftp_reply_pasv_parser_core.sv =====
// Channel  Dir  Signals                                   Word
// s_axis   in   s_axis_tvalid/tready/tdata[7:0]           one reply byte
// m_axis   out  m_axis_tvalid/tready/tdata[63:0]          one parsed reply
//
// One byte per cycle while the output is not stalled; a byte sits in the input
// register and its result, if any, goes to the output register as it leaves.
// The per-byte parse state update is the single loop that sets this rate.
// rst is synchronous, active high, and returns to the start of a reply.
// A result held in the output register stalls the byte in the input register,
// whether or not it finishes a reply, until the result is taken.
`default_nettype none

module ftp_reply_pasv_parser_core #(
  parameter int unsigned LINE_CAP  = fprp_pkg::LINE_CAP_DEF,
  parameter int unsigned REPLY_CAP = fprp_pkg::REPLY_CAP_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [9:0] reply_code, [10] hit_length_cap, [11] pasv_ok,
  // [43:12] host_address, [59:44] pasv_port, [63:60] zero
  output logic [63:0]      m_axis_tdata
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              fire;
  logic              res_valid;
  fprp_pkg::result_t res;
  fprp_pkg::result_t out_res;

  // advance whenever the output slot is free or being emptied
  assign fire = in_valid && (!m_axis_tvalid || m_axis_tready);

  fprp_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_data  (s_axis_tdata),
    .take    (fire),
    .q_valid (in_valid),
    .q_data  (in_byte)
  );

  fprp_parser #(
    .LINE_CAP  (LINE_CAP),
    .REPLY_CAP (REPLY_CAP)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (fire),
    .rx_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire && res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {(fprp_pkg::OUT_TDATA_W - fprp_pkg::RESULT_W)'(0), out_res};

`ifndef SYNTH
  a_pasv_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !out_res.pasv_ok |->
      out_res.host_address == 32'd0 && out_res.pasv_port == 16'd0)
    else $error("address or port set on failed passive parse");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_res.reply_code <= 10'd999)
    else $error("reply code out of range");

  a_stall_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while parse stage is blocked");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !(fire && res_valid) |=> !m_axis_tvalid)
    else $error("result repeated after hand-off");
`endif

endmodule

`default_nettype wire
